FILE: design/bf3_pkg.sv
// Shared constants and types for the 3x3 box filter.
`default_nettype none
package bf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int WIN_SIDE   = 3;

  localparam int PIX_W   = 8;
  localparam int COORD_W = $clog2(MAX_WIDTH);     // column / row counter and line buffer index
  localparam int SIZE_W  = 11;                    // frame size registers
  localparam int COL_W   = PIX_W + 2;             // sum of one window column
  localparam int SUM_W   = PIX_W + 4;             // sum of the whole window
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // floor(s / 9) == (s * 3641) >> 15 for every s up to 9 * 255
  localparam int                  DIV9_SHIFT = 15;
  localparam logic [SUM_W-1:0]    DIV9_MUL   = SUM_W'(3641);
  localparam int                  PROD_W     = 2 * SUM_W;

  localparam logic [SIZE_W-1:0] SIZE_MIN      = SIZE_W'(WIN_SIDE);
  localparam logic [SIZE_W-1:0] WIDTH_MAX     = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_MAX    = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] WIDTH_RESET   = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET  = SIZE_W'(1024);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              restart;   // a size register was written: start a new frame
  } cfg_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] vmax);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_MIN) begin
      r = SIZE_MIN;
    end else if (v > vmax) begin
      r = vmax;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/bf3_ifs.sv
// Stream interfaces for pixel words in and filtered words out.
`default_nettype none
interface bf3_pixel_if import bf3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bf3_result_if import bf3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   filtered_pixel;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic               last_of_frame;

  modport source (output valid, output filtered_pixel, output out_x, output out_y,
                  output last_of_frame, input ready);
  modport sink   (input valid, input filtered_pixel, input out_x, input out_y,
                  input last_of_frame, output ready);
endinterface
`default_nettype wire

FILE: design/bf3_cfg.sv
// APB register block holding the frame size.
`default_nettype none
module bf3_cfg import bf3_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  output      cfg_t               cfg
);

  logic [SIZE_W-1:0] width;
  logic [SIZE_W-1:0] height;
  logic              restart;
  logic              wr;
  reg_idx_t          idx;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // both register indexes are sizes, so every write restarts the frame at the same edge
  assign restart = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      width   <= WIDTH_RESET;
      height  <= HEIGHT_RESET;
    end else begin
      if (wr) begin
        case (idx)
          REG_WIDTH:  width  <= clamp_size(pwdata[SIZE_W-1:0], WIDTH_MAX);
          REG_HEIGHT: height <= clamp_size(pwdata[SIZE_W-1:0], HEIGHT_MAX);
          default:    ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = PDATA_W'(width);
      REG_HEIGHT: prdata = PDATA_W'(height);
      default:    prdata = '0;
    endcase
  end

  assign cfg = '{width: width, height: height, restart: restart};

endmodule
`default_nettype wire

FILE: design/bf3_line_buf.sv
// Two line buffers sharing one read and one write address, registered read.
`default_nettype none
module bf3_line_buf import bf3_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [COORD_W-1:0] rd_addr,
  input  wire logic               wr_en,
  input  wire logic [COORD_W-1:0] wr_addr,
  input  wire logic [PIX_W-1:0]   wr_upper,
  input  wire logic [PIX_W-1:0]   wr_middle,
  output      logic [PIX_W-1:0]   rd_upper,
  output      logic [PIX_W-1:0]   rd_middle
);

  logic [PIX_W-1:0] mem_upper  [MAX_WIDTH];
  logic [PIX_W-1:0] mem_middle [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[wr_addr]  <= wr_upper;
      mem_middle[wr_addr] <= wr_middle;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= mem_upper[rd_addr];
      rd_middle <= mem_middle[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/box_filter_3x3.sv
// 3x3 box filter: top level with counters, window and mean pipeline.
// Grey pixels arrive in raster order, one word per clock when the result side
// keeps up. Each pixel is written into two line buffers (the rows one and two
// above it), and the three pixels of its column enter a 3x3 window. Once the
// pixel sits at column 2 or more and row 2 or more, the truncated mean of the
// window is sent out for the window centre (column-1, row-1), with the centre's
// coordinates and a flag on the last result of the frame; border positions give
// no result. Throughput is one pixel per clock while results are taken: the
// line buffers are one read port and one write port per cycle, read when a
// pixel is taken and written back as that pixel leaves the first stage, so
// back-to-back pixels never touch the same entry. The edge that takes a pixel
// loads the memory read and pixel register; the window sum, the reciprocal
// multiply and the output register are loaded after it, in that order.
// Each stage holds its word only while the next one is full, so a new pixel is
// taken whenever a bubble exists ahead of it, also while a result waits.
// Writing either size register (APB, byte address 0 width, 4 height; values
// below 3 act as 3, above 1024 as 1024) restarts the frame at column 0, row 0;
// write only while the block is empty. The line buffers need no clearing pass.
`default_nettype none
module box_filter_3x3 import bf3_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  bf3_pixel_if.sink               pix_in,
  bf3_result_if.source            res_out
);

  cfg_t cfg;

  bf3_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------- counters
  logic [COORD_W-1:0] col_count;
  logic [COORD_W-1:0] row_count;
  logic               in_fire;
  logic               col_wrap;
  logic               row_wrap;

  assign col_wrap = (SIZE_W'(col_count) + SIZE_W'(1)) >= cfg.width;
  assign row_wrap = (SIZE_W'(row_count) + SIZE_W'(1)) >= cfg.height;

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_count + COORD_W'(1);
      end else begin
        col_count <= col_count + COORD_W'(1);
      end
    end
  end

  // ------------------------------------------------------- stage ready chain
  logic a_v, b_v, c_v, d_v;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic a_adv;

  assign rdy_d = !d_v || res_out.ready;
  assign rdy_c = !c_v || rdy_d;
  assign rdy_b = !b_v || rdy_c;
  assign rdy_a = !a_v || rdy_b;

  assign pix_in.ready = rdy_a;
  assign in_fire      = pix_in.valid && rdy_a;
  assign a_adv        = a_v && rdy_b;

  // ------------------------------------------- stage A: line buffer read out
  logic [PIX_W-1:0]   a_px;
  logic [COORD_W-1:0] a_x;
  logic [COORD_W-1:0] a_y;
  logic               a_emit;
  logic               a_last;
  logic [PIX_W-1:0]   top;
  logic [PIX_W-1:0]   mid;

  bf3_line_buf u_line_buf (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr   (col_count),
    .wr_en     (a_adv),
    .wr_addr   (a_x),
    .wr_upper  (mid),
    .wr_middle (a_px),
    .rd_upper  (top),
    .rd_middle (mid)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_px   <= pix_in.pixel;
      a_x    <= col_count;
      a_y    <= row_count;
      a_emit <= (col_count >= COORD_W'(2)) && (row_count >= COORD_W'(2));
      a_last <= (SIZE_W'(col_count) + SIZE_W'(1) == cfg.width) &&
                (SIZE_W'(row_count) + SIZE_W'(1) == cfg.height);
    end
  end

  // ------------------------ window, kept as the two older column sums, and sum
  logic [COL_W-1:0] col_sum [WIN_SIDE-1];
  logic [COL_W-1:0] new_col;
  logic [SUM_W-1:0] win_sum;

  assign new_col = COL_W'(top) + COL_W'(mid) + COL_W'(a_px);
  assign win_sum = SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(new_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_sum[0] <= '0;
      col_sum[1] <= '0;
    end else if (a_adv) begin
      // shift the window one column left, newest column on the right
      col_sum[0] <= col_sum[1];
      col_sum[1] <= new_col;
    end
  end

  // ----------------------------------------------- stage B: window sum held
  logic [SUM_W-1:0]   b_sum;
  logic [COORD_W-1:0] b_x;
  logic [COORD_W-1:0] b_y;
  logic               b_last;

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_sum  <= win_sum;
      b_x    <= a_x - COORD_W'(1);
      b_y    <= a_y - COORD_W'(1);
      b_last <= a_last;
    end
  end

  // ------------------------------------- stage C: multiply by reciprocal of 9
  logic [PROD_W-1:0]  c_prod;
  logic [COORD_W-1:0] c_x;
  logic [COORD_W-1:0] c_y;
  logic               c_last;

  always_ff @(posedge clk) begin
    if (b_v && rdy_c) begin
      c_prod <= PROD_W'(b_sum) * PROD_W'(DIV9_MUL);
      c_x    <= b_x;
      c_y    <= b_y;
      c_last <= b_last;
    end
  end

  // ------------------------------------------------ stage D: output register
  logic [PIX_W-1:0]   d_pix;
  logic [COORD_W-1:0] d_x;
  logic [COORD_W-1:0] d_y;
  logic               d_last;

  always_ff @(posedge clk) begin
    if (c_v && rdy_d) begin
      d_pix  <= c_prod[DIV9_SHIFT +: PIX_W];
      d_x    <= c_x;
      d_y    <= c_y;
      d_last <= c_last;
    end
  end

  // valid bits: only pixels with a full window go past stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_v <= pix_in.valid;
      end
      if (rdy_b) begin
        b_v <= a_v && a_emit;
      end
      if (rdy_c) begin
        c_v <= b_v;
      end
      if (rdy_d) begin
        d_v <= c_v;
      end
    end
  end

  assign res_out.valid          = d_v;
  assign res_out.filtered_pixel = d_pix;
  assign res_out.out_x          = d_x;
  assign res_out.out_y          = d_y;
  assign res_out.last_of_frame  = d_last;

endmodule
`default_nettype wire
